@@ rtl/kab64_pkg.sv @@
package kab64_pkg;

    localparam int SYM_W    = 7;
    localparam int NUM_SYM  = 64;
    localparam int SYM_IDX_W = 6;
    localparam int NUM_ALPHA_REG = 7;
    localparam int SYM_PER_REG   = 9;
    localparam int ALPHA_REG_W   = SYM_W * SYM_PER_REG;
    localparam int TAIL_W   = 15;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 6;
    localparam int REG_IDX_W = 3;
    localparam int MAX_RES  = 4;
    localparam int CNT_W    = 3;
    localparam int RES_IDX_W = 2;

    localparam logic [TAIL_W-1:0] TAIL_RESET = 15'd7808;

    // register map, by index (byte address is 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_TAIL = 3'd7;

    // tail_settings fields
    localparam int TAIL_PAD_LSB = 7;
    localparam int TAIL_DIR_BIT = 14;

    typedef logic [NUM_SYM-1:0][SYM_W-1:0] t_alpha;

    typedef struct packed {
        t_alpha             alpha;
        logic [SYM_W-1:0]   pad;
        logic               decode;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_data;
        logic       last;
        logic       bad;
    } t_res;

    typedef struct packed {
        logic                     valid;
        logic [CNT_W-1:0]         cnt;
        logic [MAX_RES-1:0][$bits(t_res)-1:0] res;
    } t_batch;

endpackage

@@ rtl/kab64_regs.sv @@
module kab64_regs
    import kab64_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [NUM_ALPHA_REG-1:0][ALPHA_REG_W-1:0] r_alpha;
    logic [TAIL_W-1:0]                         r_tail;
    logic [REG_IDX_W-1:0]                      reg_idx;
    logic                                      wr_en;

    assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= '0;
            r_tail  <= TAIL_RESET;
        end else if (wr_en) begin
            if (reg_idx == REG_TAIL) begin
                r_tail <= pwdata[TAIL_W-1:0];
            end else begin
                r_alpha[reg_idx] <= pwdata[ALPHA_REG_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == REG_TAIL) begin
            prdata = {{(DATA_W-TAIL_W){1'b0}}, r_tail};
        end else begin
            prdata = {{(DATA_W-ALPHA_REG_W){1'b0}}, r_alpha[reg_idx]};
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ALPHA_REG; r++) begin
            for (int k = 0; k < SYM_PER_REG; k++) begin
                o_cfg.alpha[r*SYM_PER_REG + k] = r_alpha[r][SYM_W*k +: SYM_W];
            end
        end
        o_cfg.alpha[NUM_SYM-1] = r_tail[SYM_W-1:0];
        o_cfg.pad              = r_tail[TAIL_PAD_LSB +: SYM_W];
        o_cfg.decode           = r_tail[TAIL_DIR_BIT];
    end

endmodule

@@ rtl/kab64_step.sv @@
module kab64_step
    import kab64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output t_batch     o_batch,
    input  logic       i_can_load
);

    logic                 r_in_v;
    logic [7:0]           r_in_char;
    logic                 r_in_last;
    logic [1:0]           r_gpos;
    logic [5:0]           r_left;

    logic [1:0]           n_gpos;
    logic [5:0]           n_left;
    logic [CNT_W-1:0]     cnt;
    t_res [MAX_RES-1:0]   res;
    logic                 fire;
    logic [7:0]           c;
    logic [SYM_IDX_W-1:0] v;
    logic                 found;
    logic                 have_byte;
    logic [7:0]           dec_byte;
    t_res                 pad_res;

    assign c    = r_in_char;
    assign fire = r_in_v && ((cnt == '0) || i_can_load);
    assign o_in_ready = !r_in_v || fire;

    assign pad_res = '{out_char: {1'b0, i_cfg.pad}, is_data: 1'b1, last: 1'b0, bad: 1'b0};

    // lowest matching index wins; a char with bit 7 set matches nothing
    always_comb begin
        v     = '0;
        found = 1'b0;
        for (int k = NUM_SYM - 1; k >= 0; k--) begin
            if (!c[7] && (i_cfg.alpha[k] == c[SYM_W-1:0])) begin
                v     = SYM_IDX_W'(k);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        n_gpos    = r_gpos;
        n_left    = r_left;
        cnt       = '0;
        res       = '0;
        have_byte = 1'b0;
        dec_byte  = '0;
        if (!i_cfg.decode) begin
            case (r_gpos)
                2'd1: begin
                    res[0] = '{{1'b0, i_cfg.alpha[{r_left[1:0], c[7:4]}]}, 1'b1, 1'b0, 1'b0};
                    cnt    = 3'd1;
                    n_left = {2'b00, c[3:0]};
                    n_gpos = 2'd2;
                    if (r_in_last) begin
                        res[1] = '{{1'b0, i_cfg.alpha[{c[3:0], 2'b00}]}, 1'b1, 1'b0, 1'b0};
                        res[2] = pad_res;
                        cnt    = 3'd3;
                    end
                end
                2'd2: begin
                    res[0] = '{{1'b0, i_cfg.alpha[{r_left[3:0], c[7:6]}]}, 1'b1, 1'b0, 1'b0};
                    res[1] = '{{1'b0, i_cfg.alpha[c[5:0]]}, 1'b1, 1'b0, 1'b0};
                    cnt    = 3'd2;
                    n_left = '0;
                    n_gpos = 2'd0;
                end
                default: begin
                    // position three only comes from decoding; it counts as zero here
                    res[0] = '{{1'b0, i_cfg.alpha[c[7:2]]}, 1'b1, 1'b0, 1'b0};
                    cnt    = 3'd1;
                    n_left = {4'b0000, c[1:0]};
                    n_gpos = 2'd1;
                    if (r_in_last) begin
                        res[1] = '{{1'b0, i_cfg.alpha[{c[1:0], 4'b0000}]}, 1'b1, 1'b0, 1'b0};
                        res[2] = pad_res;
                        res[3] = pad_res;
                        cnt    = 3'd4;
                    end
                end
            endcase
            if (r_in_last) begin
                n_gpos = '0;
                n_left = '0;
            end
        end else if (c == {1'b0, i_cfg.pad}) begin
            if (r_in_last) begin
                res[0] = '{8'h00, 1'b0, 1'b1, 1'b0};
                cnt    = 3'd1;
                n_gpos = '0;
                n_left = '0;
            end
        end else begin
            case (r_gpos)
                2'd0: begin
                    n_left = v;
                    n_gpos = 2'd1;
                end
                2'd1: begin
                    dec_byte  = {r_left, v[5:4]};
                    have_byte = 1'b1;
                    n_left    = {2'b00, v[3:0]};
                    n_gpos    = 2'd2;
                end
                2'd2: begin
                    dec_byte  = {r_left[3:0], v[5:2]};
                    have_byte = 1'b1;
                    n_left    = {4'b0000, v[1:0]};
                    n_gpos    = 2'd3;
                end
                default: begin
                    dec_byte  = {r_left[1:0], v};
                    have_byte = 1'b1;
                    n_left    = '0;
                    n_gpos    = 2'd0;
                end
            endcase
            if (r_in_last) begin
                n_gpos = '0;
                n_left = '0;
            end
            if (have_byte) begin
                res[0] = '{dec_byte, 1'b1, 1'b0, !found};
                cnt    = 3'd1;
            end else if (r_in_last || !found) begin
                res[0] = '{8'h00, 1'b0, 1'b0, !found};
                cnt    = 3'd1;
            end
        end
        // flag the final beat of the message
        for (int i = 0; i < MAX_RES; i++) begin
            if (r_in_last && (CNT_W'(i) == cnt - 3'd1)) begin
                res[i].last = 1'b1;
            end
        end
    end

    assign o_batch.valid = r_in_v && (cnt != '0);
    assign o_batch.cnt   = cnt;
    assign o_batch.res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_gpos <= '0;
            r_left <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_v <= 1'b1;
            end else if (fire) begin
                r_in_v <= 1'b0;
            end
            if (fire) begin
                r_gpos <= n_gpos;
                r_left <= n_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char <= i_in_char;
            r_in_last <= i_in_last;
        end
    end

    a_pos0_no_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gpos == 2'd0) |-> (r_left == '0))
        else $error("leftover bits held at group position zero");

    a_pos2_four_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gpos == 2'd2) |-> (r_left[5:4] == 2'b00))
        else $error("more than four leftover bits at group position two");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> ((r_gpos == '0) && (r_left == '0)))
        else $error("state not cleared after end of message");

endmodule

@@ rtl/kab64_resbuf.sv @@
module kab64_resbuf
    import kab64_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_batch     i_batch,
    output logic       o_can_load,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_out_is_data,
    output logic       o_out_last,
    output logic       o_bad_symbol
);

    t_res [MAX_RES-1:0] r_res;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_idx;
    logic               busy;
    logic               pop;
    logic               last_pop;
    t_res               cur;

    assign busy       = (r_idx != r_cnt);
    assign pop        = busy && i_out_ready;
    assign last_pop   = pop && ((r_idx + 3'd1) == r_cnt);
    assign o_can_load = !busy || last_pop;

    assign cur           = r_res[r_idx[RES_IDX_W-1:0]];
    assign o_out_valid   = busy;
    assign o_out_char    = cur.out_char;
    assign o_out_is_data = cur.is_data;
    assign o_out_last    = cur.last;
    assign o_bad_symbol  = cur.bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_batch.valid && o_can_load) begin
            r_cnt <= i_batch.cnt;
            r_idx <= '0;
        end else if (pop) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_batch.valid && o_can_load) begin
            r_res <= i_batch.res;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx <= r_cnt) && (r_cnt <= CNT_W'(MAX_RES)))
        else $error("result buffer index out of range");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_batch.valid && o_can_load) |=> o_out_valid)
        else $error("loaded batch not presented");

endmodule

@@ rtl/keyed_alphabet_base64_codec_core.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------------------------
// in       | i_in_valid / o_in_ready    | i_in_char, i_in_last
// out      | o_out_valid / i_out_ready  | o_out_char, o_out_is_data, o_out_last, o_bad_symbol
// cfg      | psel, penable, pwrite      | paddr (8 bytes a register), pwdata, prdata
//
// An item waits in the input register, then its 0 to 4 results are built in one pass and
// land in a four-entry result buffer. The output moves one beat a cycle while i_out_ready is
// high. The next batch loads in the cycle the last beat of the previous one is taken.
// Reset is synchronous: group position, leftover bits clear, input register and result buffer empty, registers reload.
// A stalled output holds its beat; the input register holds an item until its batch loads.
module keyed_alphabet_base64_codec_core
    import kab64_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_char,
    input  logic              i_in_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_char,
    output logic              o_out_is_data,
    output logic              o_out_last,
    output logic              o_bad_symbol
);

    t_cfg   cfg;
    t_batch batch;
    logic   can_load;

    kab64_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kab64_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_char  (i_in_char),
        .i_in_last  (i_in_last),
        .o_batch    (batch),
        .i_can_load (can_load)
    );

    kab64_resbuf u_resbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_batch       (batch),
        .o_can_load    (can_load),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_out_is_data (o_out_is_data),
        .o_out_last    (o_out_last),
        .o_bad_symbol  (o_bad_symbol)
    );

endmodule
